### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion helpers for the pair keyed cache
// implication and next-cycle implication checks, clocked and reset aware
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PKSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PKSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PKSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PKSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### src/pksc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pksc_pkg
// shared constants, codes and width helpers of the pair keyed cache
// ----------------------------------------------------------------------------
package pksc_pkg;

    // default geometry
    localparam int SETS_DEF       = 1024;
    localparam int WAYS_DEF       = 4;
    localparam int VALUE_BITS_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;

    // fixed field widths
    localparam int KIND_W     = 2;
    localparam int IDX_W      = 16;
    localparam int WORD_W     = 32;
    localparam int KEY_W      = 33;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FILL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CACHE_ENABLE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_INSTANCES = 8'd1;

    // set index width for a given set count
    function automatic int addr_width(input int sets);
        addr_width = (sets > 1) ? $clog2(sets) : 1;
    endfunction

    // packed command: enable, kind, diag, set, tag, fill word
    function automatic int cmd_width(input int sets);
        cmd_width = 1 + KIND_W + 1 + addr_width(sets) + KEY_W + WORD_W;
    endfunction

endpackage

### src/pksc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pksc channel interfaces
// request, result and register write channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface pksc_req_if;
    import pksc_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  index_a;
    logic [IDX_W-1:0]  index_b;
    logic [WORD_W-1:0] fill_value;

    modport source (output valid, kind, index_a, index_b, fill_value, input ready);
    modport sink   (input valid, kind, index_a, index_b, fill_value, output ready);
endinterface

interface pksc_rsp_if;
    import pksc_pkg::*;

    logic              valid;
    logic              ready;
    logic              hit;
    logic              diagonal;
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] hit_count;
    logic [WORD_W-1:0] fill_count;

    modport source (output valid, hit, diagonal, value, hit_count, fill_count, input ready);
    modport sink   (input valid, hit, diagonal, value, hit_count, fill_count, output ready);
endinterface

interface pksc_cfg_if;
    import pksc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/pksc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pksc_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pksc_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/pksc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pksc_queue
// short command queue between the front and the back end
// ----------------------------------------------------------------------------
module pksc_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = pksc_pkg::QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push_fire && !pop_fire)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop_fire && !push_fire)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### src/pksc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pksc_front
// accepts request beats, holds the registers, forms key, tag and set
// ----------------------------------------------------------------------------
module pksc_front
#(
    parameter int SETS   = pksc_pkg::SETS_DEF,
    localparam int ADDR_W = pksc_pkg::addr_width(SETS),
    localparam int CMD_W  = pksc_pkg::cmd_width(SETS)
)
(
    input  logic             clk,
    input  logic             rst_n,
    pksc_req_if.sink         req,
    pksc_cfg_if.sink         cfg,
    input  logic             clearing,
    output logic             push_valid,
    input  logic             push_ready,
    output logic [CMD_W-1:0] push_data
);

    import pksc_pkg::*;

    localparam bit IS_POW2 = ((SETS & (SETS - 1)) == 0);

    // reciprocal of the set count, sized so the quotient is exact for every key
    localparam int                SHIFT    = KEY_W + $clog2(SETS);
    localparam int                HALF_W   = (KEY_W + 2) / 2;
    localparam int                PART_W   = KEY_W + HALF_W;
    localparam int                PROD_W   = KEY_W + 2 * HALF_W;
    localparam logic [63:0]       RECIP    = ((64'd1 << SHIFT) / 64'(SETS)) + 64'd1;
    localparam logic [HALF_W-1:0] RECIP_LO = RECIP[HALF_W-1:0];
    localparam logic [HALF_W-1:0] RECIP_HI = RECIP[2*HALF_W-1:HALF_W];

    typedef enum logic [2:0] {F_IDLE, F_KEY, F_MLO, F_MHI, F_REM, F_PUSH} fstate_t;

    typedef struct packed {
        logic              enable;
        logic [KIND_W-1:0] kind;
        logic              diag;
        logic [ADDR_W-1:0] set_idx;
        logic [KEY_W-1:0]  tag;
        logic [WORD_W-1:0] fill;
    } cmd_t;

    fstate_t             state_reg;
    logic                enable_reg;
    logic [IDX_W-1:0]    ninst_reg;

    logic [IDX_W-1:0]    hi_reg;
    logic [WORD_W-1:0]   prod_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic                diag_reg;
    logic                en_reg;
    logic [WORD_W-1:0]   fill_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [PART_W-1:0]   part_reg;
    logic [KEY_W-1:0]    quot_reg;
    logic [ADDR_W-1:0]   rem_reg;

    logic                accept;
    logic                a_gt;
    logic [IDX_W-1:0]    hi;
    logic [IDX_W-1:0]    lo;
    logic [WORD_W-1:0]   prod;
    logic                diag;
    logic [KEY_W-1:0]    key;
    logic [KEY_W-1:0]    tag;
    logic [ADDR_W-1:0]   set_pow2;
    logic [PART_W-1:0]   part_lo;
    logic [PART_W-1:0]   part_hi;
    logic [PROD_W-1:0]   prod_full;
    logic [KEY_W-1:0]    quot;
    logic [KEY_W-1:0]    quot_sets;
    logic [ADDR_W-1:0]   rem_next;
    cmd_t                cmd;

    // register writes, always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            ninst_reg  <= IDX_W'(1);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_CACHE_ENABLE:  enable_reg <= cfg.data[0];
                REG_NUM_INSTANCES: ninst_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    // order the pair and multiply the smaller index
    assign accept = req.valid && req.ready;
    assign a_gt   = (req.index_a > req.index_b);
    assign hi     = a_gt ? req.index_a : req.index_b;
    assign lo     = a_gt ? req.index_b : req.index_a;
    assign prod   = WORD_W'(lo) * WORD_W'(ninst_reg);
    assign diag   = (req.kind inside {KIND_LOOKUP, KIND_FILL}) && (req.index_a == req.index_b);

    // key, tag and set from the registered product
    assign key      = KEY_W'(hi_reg) + KEY_W'(prod_reg);
    assign tag      = key + KEY_W'(1);
    assign set_pow2 = ADDR_W'(key & KEY_W'(SETS - 1));

    // set remainder: key times reciprocal in two halves, then key minus quotient times sets
    assign part_lo   = PART_W'(key_reg) * PART_W'(RECIP_LO);
    assign part_hi   = PART_W'(key_reg) * PART_W'(RECIP_HI);
    assign prod_full = {part_hi, {HALF_W{1'b0}}} + PROD_W'(part_reg);
    assign quot      = KEY_W'(prod_full >> SHIFT);
    assign quot_sets = quot_reg * KEY_W'(SETS);
    assign rem_next  = ADDR_W'(key_reg - quot_sets);

    assign req.ready  = (state_reg == F_IDLE) && !clearing;
    assign push_valid = ((state_reg == F_KEY) && IS_POW2) || (state_reg == F_PUSH);

    always_comb
    begin
        cmd.enable  = en_reg;
        cmd.kind    = kind_reg;
        cmd.diag    = diag_reg;
        cmd.set_idx = IS_POW2 ? set_pow2 : rem_reg;
        cmd.tag     = tag;
        cmd.fill    = fill_reg;
    end

    assign push_data = cmd;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= F_KEY;
                    end
                end
                F_KEY:
                begin
                    if (IS_POW2)
                    begin
                        if (push_ready)
                        begin
                            state_reg <= F_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= F_MLO;
                    end
                end
                F_MLO:
                begin
                    state_reg <= F_MHI;
                end
                F_MHI:
                begin
                    state_reg <= F_REM;
                end
                F_REM:
                begin
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (push_ready)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    // item payload and remainder datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hi_reg   <= hi;
            prod_reg <= prod;
            kind_reg <= req.kind;
            diag_reg <= diag;
            en_reg   <= enable_reg;
            fill_reg <= req.fill_value;
        end
        if (state_reg == F_KEY)
        begin
            key_reg <= key;
        end
        if (state_reg == F_MLO)
        begin
            part_reg <= part_lo;
        end
        if (state_reg == F_MHI)
        begin
            quot_reg <= quot;
        end
        if (state_reg == F_REM)
        begin
            rem_reg <= rem_next;
        end
    end

endmodule

### src/pksc_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// pksc_back
// reads a set row, resolves hit, move-to-front or insert, writes it back
// ----------------------------------------------------------------------------
module pksc_back
#(
    parameter int SETS       = pksc_pkg::SETS_DEF,
    parameter int WAYS       = pksc_pkg::WAYS_DEF,
    parameter int VALUE_BITS = pksc_pkg::VALUE_BITS_DEF,
    localparam int ADDR_W    = pksc_pkg::addr_width(SETS),
    localparam int CMD_W     = pksc_pkg::cmd_width(SETS)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  logic [CMD_W-1:0] pop_data,
    pksc_rsp_if.source       rsp,
    output logic             clearing
);

    import pksc_pkg::*;

    localparam int ENTRY_W = KEY_W + VALUE_BITS;
    localparam int ROW_W   = WAYS * ENTRY_W;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_UPDATE} bstate_t;

    typedef struct packed {
        logic              enable;
        logic [KIND_W-1:0] kind;
        logic              diag;
        logic [ADDR_W-1:0] set_idx;
        logic [KEY_W-1:0]  tag;
        logic [WORD_W-1:0] fill;
    } cmd_t;

    bstate_t               state_reg;
    logic [ADDR_W-1:0]     clr_addr_reg;
    logic                  out_valid_reg;
    logic [WORD_W-1:0]     hits_reg;
    logic [WORD_W-1:0]     fills_reg;
    cmd_t                  cmd_reg;
    logic                  hit_reg;
    logic                  diag_reg;
    logic [WORD_W-1:0]     value_reg;

    cmd_t                  pop_cmd;
    logic                  pop_fire;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ROW_W-1:0]      ram_wdata;
    logic [ROW_W-1:0]      row;
    logic [ROW_W-1:0]      new_row;

    logic [KEY_W-1:0]      tags [WAYS];
    logic [VALUE_BITS-1:0] vals [WAYS];
    logic                  access;
    logic                  insert;
    logic                  alive;
    logic                  found;
    logic [WAY_W-1:0]      hit_way;
    logic                  hit;
    logic [VALUE_BITS-1:0] hit_val;
    logic [VALUE_BITS-1:0] fill_val;

    assign pop_cmd   = pop_data;
    assign pop_ready = (state_reg == B_IDLE) && (!out_valid_reg || rsp.ready);
    assign pop_fire  = pop_valid && pop_ready;
    assign clearing  = (state_reg == B_CLEAR);

    // set rows: all ways of one set side by side
    assign ram_we    = (state_reg == B_CLEAR) || (state_reg == B_UPDATE);
    assign ram_waddr = (state_reg == B_CLEAR) ? clr_addr_reg : cmd_reg.set_idx;
    assign ram_wdata = (state_reg == B_CLEAR) ? '0 : new_row;

    pksc_ram
    #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    )
    u_row_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (pop_fire),
        .raddr (pop_cmd.set_idx),
        .rdata (row)
    );

    // split the row into ways
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            tags[w] = row[w*ENTRY_W +: KEY_W];
            vals[w] = row[w*ENTRY_W + KEY_W +: VALUE_BITS];
        end
    end

    // scan in way order, stop at the first empty way
    assign access = cmd_reg.enable && !cmd_reg.diag &&
                    (cmd_reg.kind inside {KIND_LOOKUP, KIND_FILL});

    always_comb
    begin
        alive   = 1'b1;
        found   = 1'b0;
        hit_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (alive && !found && (tags[w] == cmd_reg.tag))
            begin
                found   = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (tags[w] == '0)
            begin
                alive = 1'b0;
            end
        end
    end

    assign hit      = access && found;
    assign insert   = access && !found && (cmd_reg.kind == KIND_FILL);
    assign hit_val  = vals[hit_way];
    assign fill_val = VALUE_BITS'(cmd_reg.fill);

    // swap the hit way to the front, or push the new entry in at way 0
    always_comb
    begin
        new_row = row;
        if (hit)
        begin
            new_row[0 +: KEY_W]          = tags[hit_way];
            new_row[KEY_W +: VALUE_BITS] = hit_val;
            for (int w = 1; w < WAYS; w++)
            begin
                if (WAY_W'(w) == hit_way)
                begin
                    new_row[w*ENTRY_W +: KEY_W]              = tags[0];
                    new_row[w*ENTRY_W + KEY_W +: VALUE_BITS] = vals[0];
                end
            end
        end
        else if (insert)
        begin
            new_row[0 +: KEY_W]          = cmd_reg.tag;
            new_row[KEY_W +: VALUE_BITS] = fill_val;
            for (int w = 1; w < WAYS; w++)
            begin
                new_row[w*ENTRY_W +: KEY_W]              = tags[w-1];
                new_row[w*ENTRY_W + KEY_W +: VALUE_BITS] = vals[w-1];
            end
        end
    end

    // sequencer, counters and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            hits_reg      <= '0;
            fills_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                B_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (clr_addr_reg == ADDR_W'(SETS - 1))
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                B_IDLE:
                begin
                    if (pop_fire)
                    begin
                        state_reg <= B_UPDATE;
                    end
                end
                B_UPDATE:
                begin
                    state_reg <= B_IDLE;
                    if (cmd_reg.kind == KIND_CLEAR)
                    begin
                        hits_reg  <= '0;
                        fills_reg <= '0;
                    end
                    else
                    begin
                        hits_reg  <= hits_reg + WORD_W'(hit);
                        fills_reg <= fills_reg +
                                     WORD_W'(cmd_reg.enable && (cmd_reg.kind == KIND_FILL));
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase

            if (state_reg == B_UPDATE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        if (pop_fire)
        begin
            cmd_reg <= pop_cmd;
        end
        if (state_reg == B_UPDATE)
        begin
            hit_reg   <= hit;
            diag_reg  <= cmd_reg.diag;
            value_reg <= hit ? WORD_W'(hit_val) : '0;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = hit_reg;
    assign rsp.diagonal   = diag_reg;
    assign rsp.value      = value_reg;
    assign rsp.hit_count  = hits_reg;
    assign rsp.fill_count = fills_reg;

    // checks
    `PKSC_ASSERT_IMP(a_slot_free, clk, rst_n, state_reg == B_UPDATE, !out_valid_reg, "result slot busy at update")
    `PKSC_ASSERT_NXT(a_pop_update, clk, rst_n, pop_fire, state_reg == B_UPDATE, "popped beat not updated next cycle")
    `PKSC_ASSERT_NXT(a_clear_cnt, clk, rst_n, (state_reg == B_UPDATE) && (cmd_reg.kind == KIND_CLEAR), (hits_reg == '0) && (fills_reg == '0), "counters not cleared")
    `PKSC_ASSERT_NXT(a_hit_step, clk, rst_n, (state_reg == B_UPDATE) && (cmd_reg.kind != KIND_CLEAR), (hits_reg == $past(hits_reg)) || (hits_reg == $past(hits_reg) + 32'd1), "hit counter jumped")

endmodule

### src/pair_keyed_set_assoc_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_keyed_set_assoc_cache
// move-to-front set associative cache of values keyed by an index pair
// ----------------------------------------------------------------------------
//   port   dir   beat
//   req    in    kind, index_a, index_b, fill_value
//   rsp    out   hit, diagonal, value, hit_count, fill_count
//   cfg    in    index (0 cache_enable, 1 num_instances), data
//
// one rsp beat per req beat, in order. the front takes a beat and forms the
// key; the back reads the set row and writes it back (one ram read, one ram
// write), and takes no new beat before the last one is written back. for a
// set count that is not a power of two the front adds the mlo, mhi, rem and
// push states per beat to take the set remainder by reciprocal multiplication.
// after reset a clearing pass over every set empties the row ram; req is not
// taken during it, cfg is. a two-entry queue and the rsp output register let
// both sides stall independently.
module pair_keyed_set_assoc_cache
#(
    parameter int SETS       = pksc_pkg::SETS_DEF,
    parameter int WAYS       = pksc_pkg::WAYS_DEF,
    parameter int VALUE_BITS = pksc_pkg::VALUE_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    pksc_req_if.sink   req,
    pksc_rsp_if.source rsp,
    pksc_cfg_if.sink   cfg
);

    import pksc_pkg::*;

    localparam int CMD_W = cmd_width(SETS);

    logic             push_valid;
    logic             push_ready;
    logic [CMD_W-1:0] push_data;
    logic             pop_valid;
    logic             pop_ready;
    logic [CMD_W-1:0] pop_data;
    logic             clearing;

    // key forming front end
    pksc_front
    #(
        .SETS (SETS)
    )
    u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg),
        .clearing   (clearing),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // command queue
    pksc_queue
    #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // set update back end
    pksc_back
    #(
        .SETS       (SETS),
        .WAYS       (WAYS),
        .VALUE_BITS (VALUE_BITS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .rsp       (rsp),
        .clearing  (clearing)
    );

endmodule
